FILE: sv/rwmf_pkg.sv
// shared types, constants and compare helpers for the rgb window median filter
package rwmf_pkg;

	localparam int PIX_W   = 24;
	localparam int ROW_W   = 13;
	localparam int WIN_N   = 9;
	localparam int BANKS   = 4;
	localparam int QDEPTH  = 8;
	localparam int QAW     = 3;
	localparam int QCW     = 4;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT  = 2'd1,
		REG_WINDOW_RADIUS = 2'd2
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [1:0] bank_t;

	typedef struct packed {
		logic [11:0] frame_width;
		logic [12:0] frame_height;
		logic        window_radius;
	} cfg_t;

	typedef struct packed {
		pixel_t [WIN_N-1:0] px;
		logic               last;
	} win_t;

	// ascending, element 0 is the smallest
	function automatic logic [2:0][7:0] sort3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [7:0] x, y, z, t;
		x = a;
		y = b;
		z = c;
		if (x > y) begin
			t = x; x = y; y = t;
		end
		if (y > z) begin
			t = y; y = z; z = t;
		end
		if (x > y) begin
			t = x; x = y; y = t;
		end
		return {z, y, x};
	endfunction

	function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [2:0][7:0] s;
		s = sort3(a, b, c);
		return s[2];
	endfunction

	function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [2:0][7:0] s;
		s = sort3(a, b, c);
		return s[0];
	endfunction

	function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic [2:0][7:0] s;
		s = sort3(a, b, c);
		return s[1];
	endfunction

endpackage

FILE: sv/rgb_window_median_filter_top.sv
// top level of the streaming rgb window median filter
//
// usage: pixels arrive in raster order on the s_axis channel with tuser low;
// once the last pixel of the frame is in, requests with tuser high drain the
// remaining results one per request. each result on m_axis is the per-channel
// median of the 3x3 window (radius 1) or the pixel itself (radius 0), with edge
// pixels replicated; tlast marks the final result of the frame.
// frame size and radius are set through the cfg write port while idle.
// throughput: one request per cycle while the queue credit allows, set by the line store
// (four row banks, two read ports each) and the fully pipelined median network.
// path: a request that releases a result passes three front stages, the queue
// and three median stages before the result is valid on m_axis.
// results lag the pixel stream by radius rows plus radius pixels.
// reset clears positions, stage valids and the queue; the line store is not
// cleared, it is always written before it is read.
// a stalled receiver fills the output register, median stages and queue; the
// front stops taking requests when the queue has no room left for windows in
// flight, so nothing is lost.
module rgb_window_median_filter_top #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // in_red[7:0], in_green[15:8], in_blue[23:16]
	input  logic        s_axis_tuser,  // cmd: low pixel, high drain
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_red[7:0], out_green[15:8], out_blue[23:16]
	output logic        m_axis_tlast   // last_of_frame
);

	rwmf_pkg::cfg_t                cfg_q;
	logic                          win_valid, q_valid, q_pop;
	rwmf_pkg::win_t                win, q_win;
	logic [rwmf_pkg::QCW-1:0]      q_count;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= 12'd640;
			cfg_q.frame_height  <= 13'd480;
			cfg_q.window_radius <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				rwmf_pkg::REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data[11:0];
				rwmf_pkg::REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_data;
				rwmf_pkg::REG_WINDOW_RADIUS: cfg_q.window_radius <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front end: intake, line store, window gathering
	rwmf_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_pix    (s_axis_tdata),
		.q_count   (q_count),
		.win_valid (win_valid),
		.win       (win)
	);

	// decoupling queue of gathered windows
	rwmf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (win_valid),
		.din       (win),
		.pop       (q_pop),
		.not_empty (q_valid),
		.dout      (q_win),
		.count     (q_count)
	);

	// back end: median network and output register
	rwmf_median u_median (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_pop),
		.win       (q_win),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	// queue never holds more than its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= rwmf_pkg::QCW'(rwmf_pkg::QDEPTH))
		else $error("window queue over depth");

	// credit scheme keeps a slot free for every window leaving the front
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid |-> q_count < rwmf_pkg::QCW'(rwmf_pkg::QDEPTH))
		else $error("window pushed into a full queue");

	// with the queue full the front takes no further requests
	a_no_ready_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count == rwmf_pkg::QCW'(rwmf_pkg::QDEPTH)) |-> !s_axis_tready)
		else $error("front accepting with a full queue");

endmodule

FILE: sv/rwmf_front.sv
// front end: request intake, position tracking, line store and window gathering
module rwmf_front #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rwmf_pkg::cfg_t            cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      in_cmd,
	input  rwmf_pkg::pixel_t          in_pix,
	input  logic [rwmf_pkg::QCW-1:0]  q_count,
	output logic                      win_valid,
	output rwmf_pkg::win_t            win
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = CW + 1;
	localparam int RW = rwmf_pkg::ROW_W;

	logic [EW-1:0] w_eff;
	logic [CW-1:0] w_m1;
	logic [RW-1:0] h_m1;
	logic          r;

	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic          ic_q;

	logic          acc, pix_do, pix_emit, emit, row_end_in, frame_end_in, last;
	logic [CW-1:0] wc;
	logic [RW-1:0] yc, ya, yb, ya_raw;
	logic [RW:0]   yb_raw;
	logic [CW-1:0] xc, xl, xr, xl_raw;
	logic [CW:0]   xr_raw;

	// stage 1: store write and window addresses
	logic                  v_s1, we_s1, last_s1, leq_s1;
	rwmf_pkg::bank_t       wbank_s1, ba_s1, bc_s1, bb_s1;
	logic [CW-1:0]         wcol_s1, xc_s1, xr_s1;
	rwmf_pkg::pixel_t      pix_s1;
	// stage 2: store read
	logic                  v_s2, last_s2, leq_s2;
	rwmf_pkg::bank_t       ba_s2, bc_s2, bb_s2;
	logic [CW-1:0]         xc_s2, xr_s2;
	// stage 3: read data
	logic                  v_s3, last_s3, leq_s3;
	rwmf_pkg::bank_t       ba_s3, bc_s3, bb_s3;
	rwmf_pkg::pixel_t      rdc_s3 [rwmf_pkg::BANKS];
	rwmf_pkg::pixel_t      rdr_s3 [rwmf_pkg::BANKS];
	rwmf_pkg::pixel_t      prev_q [3];

	logic [rwmf_pkg::QCW:0] pending;

	always_comb begin
		if (cfg.frame_width == 12'd0) begin
			w_eff = EW'(1);
		end else if (int'(cfg.frame_width) > MAX_WIDTH) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(cfg.frame_width);
		end
		w_m1 = CW'(w_eff - EW'(1));
		h_m1 = (cfg.frame_height == '0) ? '0 : cfg.frame_height - RW'(1);
		r    = cfg.window_radius;
	end

	// credit: queue entries plus windows still in the front stages
	assign pending  = (rwmf_pkg::QCW+1)'(q_count) + (rwmf_pkg::QCW+1)'(v_s1)
		+ (rwmf_pkg::QCW+1)'(v_s2) + (rwmf_pkg::QCW+1)'(v_s3);
	assign in_ready = pending < (rwmf_pkg::QCW+1)'(rwmf_pkg::QDEPTH);
	assign acc      = in_valid && in_ready;

	always_comb begin
		wc           = (in_col_q > w_m1) ? w_m1 : in_col_q;
		pix_do       = acc && !in_cmd && !ic_q;
		pix_emit     = pix_do && (!r || in_row_q >= RW'(2) || (in_row_q == RW'(1) && wc != '0));
		emit         = pix_emit || (acc && in_cmd && ic_q);
		row_end_in   = wc >= w_m1;
		frame_end_in = row_end_in && in_row_q >= h_m1;
		last         = out_row_q >= h_m1 && out_col_q >= w_m1;

		yc     = (out_row_q > h_m1) ? h_m1 : out_row_q;
		ya_raw = (out_row_q < RW'(r)) ? '0 : out_row_q - RW'(r);
		ya     = (ya_raw > h_m1) ? h_m1 : ya_raw;
		yb_raw = (RW+1)'(out_row_q) + (RW+1)'(r);
		yb     = (yb_raw > (RW+1)'(h_m1)) ? h_m1 : yb_raw[RW-1:0];

		xc     = (out_col_q > w_m1) ? w_m1 : out_col_q;
		xl_raw = (out_col_q < CW'(r)) ? '0 : out_col_q - CW'(r);
		xl     = (xl_raw > w_m1) ? w_m1 : xl_raw;
		xr_raw = (CW+1)'(out_col_q) + (CW+1)'(r);
		xr     = (xr_raw > (CW+1)'(w_m1)) ? w_m1 : xr_raw[CW-1:0];
	end

	// the final result of a frame returns every position to the start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			ic_q      <= 1'b0;
		end else if (emit && last) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			ic_q      <= 1'b0;
		end else begin
			if (pix_do) begin
				if (frame_end_in) begin
					ic_q <= 1'b1;
				end else if (row_end_in) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= wc + CW'(1);
				end
			end
			if (emit) begin
				if (out_col_q >= w_m1) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			we_s1 <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
		end else begin
			v_s1  <= emit;
			we_s1 <= pix_do;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		wbank_s1 <= in_row_q[1:0];
		wcol_s1  <= wc;
		pix_s1   <= in_pix;
		last_s1  <= last;
		ba_s1    <= ya[1:0];
		bc_s1    <= yc[1:0];
		bb_s1    <= yb[1:0];
		xc_s1    <= xc;
		xr_s1    <= xr;
		leq_s1   <= xl == xc;

		last_s2  <= last_s1;
		leq_s2   <= leq_s1;
		ba_s2    <= ba_s1;
		bc_s2    <= bc_s1;
		bb_s2    <= bb_s1;
		xc_s2    <= xc_s1;
		xr_s2    <= xr_s1;

		last_s3  <= last_s2;
		leq_s3   <= leq_s2;
		ba_s3    <= ba_s2;
		bc_s3    <= bc_s2;
		bb_s3    <= bb_s2;
	end

	// one bank per row modulo four, written from stage 1, read from stage 2
	for (genvar b = 0; b < rwmf_pkg::BANKS; b++) begin : g_bank
		rwmf_pkg::pixel_t row_mem_q [MAX_WIDTH];

		always_ff @(posedge clk) begin
			if (we_s1 && wbank_s1 == rwmf_pkg::bank_t'(b)) begin
				row_mem_q[wcol_s1] <= pix_s1;
			end
			if (v_s2) begin
				rdc_s3[b] <= row_mem_q[xc_s2];
				rdr_s3[b] <= row_mem_q[xr_s2];
			end
		end
	end

	// left column is the previous centre column unless it equals the centre (row start or radius 0)
	always_comb begin
		win.px[0] = leq_s3 ? rdc_s3[ba_s3] : prev_q[0];
		win.px[1] = rdc_s3[ba_s3];
		win.px[2] = rdr_s3[ba_s3];
		win.px[3] = leq_s3 ? rdc_s3[bc_s3] : prev_q[1];
		win.px[4] = rdc_s3[bc_s3];
		win.px[5] = rdr_s3[bc_s3];
		win.px[6] = leq_s3 ? rdc_s3[bb_s3] : prev_q[2];
		win.px[7] = rdc_s3[bb_s3];
		win.px[8] = rdr_s3[bb_s3];
		win.last  = last_s3;
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			prev_q[0] <= rdc_s3[ba_s3];
			prev_q[1] <= rdc_s3[bc_s3];
			prev_q[2] <= rdc_s3[bb_s3];
		end
	end

	assign win_valid = v_s3;

endmodule

FILE: sv/rwmf_queue.sv
// small window queue between front end and median back end
module rwmf_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  rwmf_pkg::win_t            din,
	input  logic                      pop,
	output logic                      not_empty,
	output rwmf_pkg::win_t            dout,
	output logic [rwmf_pkg::QCW-1:0]  count
);

	rwmf_pkg::win_t            buf_q [rwmf_pkg::QDEPTH];
	logic [rwmf_pkg::QAW-1:0]  wp_q, rp_q;
	logic [rwmf_pkg::QCW-1:0]  cnt_q;
	logic                      do_pop;

	assign not_empty = cnt_q != '0;
	assign do_pop    = pop && not_empty;
	assign dout      = buf_q[rp_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + rwmf_pkg::QAW'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + rwmf_pkg::QAW'(1);
			end
			cnt_q <= cnt_q + rwmf_pkg::QCW'(push) - rwmf_pkg::QCW'(do_pop);
		end
	end

endmodule

FILE: sv/rwmf_median.sv
// back end: per-channel median of nine, pipelined, with output register
module rwmf_median (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rwmf_pkg::win_t   win,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [23:0]      out_data,
	output logic             out_last
);

	logic                      v1_s1, v2_s2, last_s1, last_s2;
	logic [2:0][2:0][2:0][7:0] srt_s1;
	logic [2:0][2:0][7:0]      lmh_s2;
	logic                      rdy1, rdy2, rdy3;

	assign rdy3     = !out_valid || out_ready;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) out_valid <= v2_s2;
		end
	end

	// sort each group of three, then diagonal of the sorted groups
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			last_s1 <= win.last;
			for (int c = 0; c < 3; c++) begin
				for (int g = 0; g < 3; g++) begin
					srt_s1[c][g] <= rwmf_pkg::sort3(win.px[3*g][8*c +: 8],
						win.px[3*g+1][8*c +: 8], win.px[3*g+2][8*c +: 8]);
				end
			end
		end
		if (rdy2 && v1_s1) begin
			last_s2 <= last_s1;
			for (int c = 0; c < 3; c++) begin
				lmh_s2[c][0] <= rwmf_pkg::max3(srt_s1[c][0][0], srt_s1[c][1][0], srt_s1[c][2][0]);
				lmh_s2[c][1] <= rwmf_pkg::med3(srt_s1[c][0][1], srt_s1[c][1][1], srt_s1[c][2][1]);
				lmh_s2[c][2] <= rwmf_pkg::min3(srt_s1[c][0][2], srt_s1[c][1][2], srt_s1[c][2][2]);
			end
		end
		if (rdy3 && v2_s2) begin
			out_last <= last_s2;
			for (int c = 0; c < 3; c++) begin
				out_data[8*c +: 8] <= rwmf_pkg::med3(lmh_s2[c][0], lmh_s2[c][1], lmh_s2[c][2]);
			end
		end
	end

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the rgb window median filter
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       last;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} px_result_t;

	// holds the filter's own state and the queue of medians still to arrive
	class median_scoreboard;
		logic [23:0]  rows [4][2048];
		int unsigned  col_in, row_in, col_out, row_out;
		bit           frame_in;
		int unsigned  fw, fh, rad;
		px_result_t   pending [$];
		int unsigned  errors, checked;

		function void clear();
			col_in = 0; row_in = 0; col_out = 0; row_out = 0;
			frame_in = 0;
			fw = 640; fh = 480; rad = 1;
			pending.delete();
		endfunction

		function void set_reg(rwmf_pkg::reg_idx_t idx, logic [12:0] val);
			case (idx)
				rwmf_pkg::REG_FRAME_WIDTH: begin
					fw = 32'(val[11:0]);
				end
				rwmf_pkg::REG_FRAME_HEIGHT: begin
					fh = 32'(val);
				end
				rwmf_pkg::REG_WINDOW_RADIUS: begin
					rad = 32'(val[0]);
				end
				default: ;
			endcase
		endfunction

		function int unsigned wid();
			return (fw == 0) ? 1 : (fw > 2048 ? 2048 : fw);
		endfunction

		function int unsigned hgt();
			return (fh == 0) ? 1 : fh;
		endfunction

		function int unsigned clampc(int v, int unsigned lim);
			if (v < 0) return 0;
			if (v > int'(lim) - 1) return lim - 1;
			return unsigned'(v);
		endfunction

		function logic [7:0] middle(logic [7:0] v [9], int n);
			logic [7:0] s [9];
			logic [7:0] t;
			int i, j;
			for (i = 0; i < n; i++) s[i] = v[i];
			for (i = 1; i < n; i++)
				for (j = i; j > 0 && s[j-1] > s[j]; j--) begin
					t = s[j]; s[j] = s[j-1]; s[j-1] = t;
				end
			return s[n/2];
		endfunction

		function void release_median();
			int unsigned w, h, y, x;
			int n, dy, dx;
			logic [7:0] r [9];
			logic [7:0] g [9];
			logic [7:0] b [9];
			px_result_t e;
			w = wid(); h = hgt(); n = 0;
			for (dy = -int'(rad); dy <= int'(rad); dy++) begin
				y = clampc(int'(row_out) + dy, h) % 4;
				for (dx = -int'(rad); dx <= int'(rad); dx++) begin
					x = clampc(int'(col_out) + dx, w);
					r[n] = rows[y][x][23:16];
					g[n] = rows[y][x][15:8];
					b[n] = rows[y][x][7:0];
					n++;
				end
			end
			e.red = middle(r, n);
			e.green = middle(g, n);
			e.blue = middle(b, n);
			if (row_out >= h - 1 && col_out >= w - 1) begin
				e.last = 1;
				col_in = 0; row_in = 0; col_out = 0; row_out = 0; frame_in = 0;
			end else begin
				e.last = 0;
				if (col_out + 1 >= w) begin
					col_out = 0;
					row_out++;
				end else col_out++;
			end
			pending = {pending, e};
		endfunction

		// note one accepted request
		function void note_request(logic drain, logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
			int unsigned w, h, c;
			longint unsigned p;
			w = wid(); h = hgt();
			if (drain) begin
				if (frame_in) release_median();
				return;
			end
			if (frame_in) return;
			c = (col_in >= w) ? w - 1 : col_in;
			p = longint'(row_in) * w + c;
			rows[row_in % 4][c] = {rd, gr, bl};
			if (row_in >= h - 1 && c >= w - 1) frame_in = 1;
			else if (c + 1 >= w) begin
				col_in = 0;
				row_in++;
			end else col_in = c + 1;
			if (p >= longint'(rad) * w + rad) release_median();
		endfunction

		function void check_result(px_result_t got);
			px_result_t e;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp r%h g%h b%h l%b  got r%h g%h b%h l%b",
						e.red, e.green, e.blue, e.last, got.red, got.green, got.blue, got.last);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = 0;
	logic [12:0] cfg_data = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = 0;
	logic        s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;

	median_scoreboard sb;
	int unsigned cycles = 0;
	int unsigned sent = 0;
	int unsigned frames = 0;
	bit          calm = 0;   // no idling in the last part of the run

	always #6 clk = ~clk;

	rgb_window_median_filter_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stall bursts, check every accepted result
	initial begin
		int unsigned stall;
		px_result_t got;
		sb = new();
		sb.clear();
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.red = m_axis_tdata[7:0];
				got.green = m_axis_tdata[15:8];
				got.blue = m_axis_tdata[23:16];
				got.last = m_axis_tlast;
				sb.check_result(got);
			end
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 6) - 1;
				m_axis_tready <= 0;
			end else m_axis_tready <= 1;
		end
	end

	// one request; holds until accepted, random gap bursts before it
	task automatic send_request(input logic drain, input logic [23:0] rgb);
		int unsigned gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= drain;
		s_axis_tdata <= {rgb[7:0], rgb[15:8], rgb[23:16]}; // blue high, red low
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(drain, rgb[23:16], rgb[15:8], rgb[7:0]);
		sent++;
	endtask

	task automatic settle();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input rwmf_pkg::reg_idx_t idx, input logic [12:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	// one frame: settle, config writes, pixels (values picked by mode) with stray requests, then drains
	task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned r,
			input int mode);
		int unsigned i, n;
		logic [23:0] v;
		settle();
		write_reg(rwmf_pkg::REG_FRAME_WIDTH, 13'(w));
		write_reg(rwmf_pkg::REG_FRAME_HEIGHT, 13'(h));
		write_reg(rwmf_pkg::REG_WINDOW_RADIUS, 13'(r));
		n = sb.wid() * sb.hgt();
		// drain before frame complete is ignored
		if ($urandom_range(0, 3) == 0) send_request(1, 24'($urandom));
		for (i = 0; i < n; i++) begin
			case (mode)
				0: v = 24'($urandom);
				1: v = (i % 2) ? 24'hffffff : 24'h000000;
				default: v = {8'($urandom_range(0, 3) * 85), 8'($urandom_range(250, 255)),
					8'($urandom_range(0, 5))};
			endcase
			send_request(0, v);
		end
		// pixel after frame complete is ignored while results are pending
		if (sb.frame_in && $urandom_range(0, 2) == 0) send_request(0, 24'($urandom));
		while (sb.frame_in) send_request(1, 24'($urandom));
		frames++;
	endtask

	initial begin
		int unsigned k;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: single pixel, single row and column, radius 0 and 1, extremes
		run_frame(1, 1, 1, 1);
		run_frame(0, 0, 0, 0);
		run_frame(5, 1, 1, 1);
		run_frame(1, 4, 1, 0);
		run_frame(3, 3, 0, 2);
		// a wider frame of two rows and a tall single column, kept short
		run_frame(120, 2, 1, 0);
		run_frame(1, 40, 1, 2);
		// random small frames
		while (sent < 900) begin
			if (sent > 750) calm = 1;
			k = $urandom_range(0, 2);
			run_frame($urandom_range(1, 9), $urandom_range(1, 7), $urandom_range(0, 1), k);
		end
		settle();
		repeat (20) @(posedge clk);
		$display("covered %0d frames, %0d requests, %0d results checked", frames, sent,
			sb.checked);
		$display("sizes from one pixel to wide rows, radius 0 and 1, ignored requests");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule
